/* design/header_trailer_frame_receiver_macros.svh */
// Assertion macros shared by the frame receiver checker.
`ifndef HEADER_TRAILER_FRAME_RECEIVER_MACROS_SVH
`define HEADER_TRAILER_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HTFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/htfr_pkg.sv */
// Shared types and constants for the header/trailer frame receiver.
`timescale 1ns / 1ps

package htfr_pkg;

   // Frame buffer depth; ends a frame when the count reaches it.
   localparam int BUF_DEPTH = 32768;
   localparam int ADDR_W    = 15;
   localparam int LEN_W     = 16;
   localparam int IDX_W     = 3;

   // Register indexes on the csr port.
   localparam logic [IDX_W-1:0] REG_HEADER_FIRST   = 3'd0;
   localparam logic [IDX_W-1:0] REG_HEADER_SECOND  = 3'd1;
   localparam logic [IDX_W-1:0] REG_TRAILER_FIRST  = 3'd2;
   localparam logic [IDX_W-1:0] REG_TRAILER_SECOND = 3'd3;
   localparam logic [IDX_W-1:0] REG_MAX_LENGTH     = 3'd4;

   // Reset values of the registers.
   localparam logic [7:0]       RST_HEADER_FIRST   = 8'h43;
   localparam logic [7:0]       RST_HEADER_SECOND  = 8'hC6;
   localparam logic [7:0]       RST_TRAILER_FIRST  = 8'hC5;
   localparam logic [7:0]       RST_TRAILER_SECOND = 8'hDB;
   localparam logic [LEN_W-1:0] RST_MAX_LENGTH     = 16'd24576;

   typedef struct packed {
      logic [7:0]       header_first;
      logic [7:0]       header_second;
      logic [7:0]       trailer_first;
      logic [7:0]       trailer_second;
      logic [LEN_W-1:0] max_length;
   } cfg_type;

   typedef struct packed {
      logic              write_valid;
      logic [ADDR_W-1:0] write_addr;
      logic [7:0]        write_data;
      logic              frame_done;
      logic              end_cause;
      logic [LEN_W-1:0]  frame_length;
   } result_type;

endpackage

/* design/header_trailer_frame_receiver.sv */
// Top level of the header/trailer frame receiver.
`timescale 1ns / 1ps
//
// Usage:
//   req_*  : one received byte per word (req_rx_byte), valid/ready.
//   rsp_*  : one result word per byte: buffer write (valid, addr, data) and
//            the frame-done pulse with end cause and frame length.
//   csr_*  : write-only registers; index 0..4 = header_first, header_second,
//            trailer_first, trailer_second, max_length. Write while idle.
// Path: an accepted byte sits in the input register, and the phase
//   update writes its result into the result queue, which drives rsp_*.
// Throughput: one word per cycle while the result queue has room; the
//   phase/count update is a single compare-and-increment step, so
//   back-to-back bytes wait only on a full queue. Stall: a two-word result
//   queue keeps req_ready high while one result waits; req_ready drops only
//   when the queue is full and the input register holds a word.
// Reset: registers return to 0x43/0xC6/0xC5/0xDB/24576, the hunt restarts
//   at the first header byte, the byte count clears and all words in flight
//   are dropped.

module header_trailer_frame_receiver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_write_valid,
   output logic [htfr_pkg::ADDR_W-1:0]   rsp_write_addr,
   output logic [7:0]                    rsp_write_data,
   output logic                          rsp_frame_done,
   output logic                          rsp_end_cause,
   output logic [htfr_pkg::LEN_W-1:0]    rsp_frame_length,
   input  logic                          csr_write_enable,
   input  logic [htfr_pkg::IDX_W-1:0]    csr_index,
   input  logic [htfr_pkg::LEN_W-1:0]    csr_write_data
);
   import htfr_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       advance;
   result_type res;

   // result queue, two words
   result_type q_ff [2];
   logic       q_head_ff, q_tail_ff;
   logic [1:0] q_count_ff;
   logic       pop;
   result_type q_out;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_HEADER_FIRST:   cfg_in.header_first   = csr_write_data[7:0];
            REG_HEADER_SECOND:  cfg_in.header_second  = csr_write_data[7:0];
            REG_TRAILER_FIRST:  cfg_in.trailer_first  = csr_write_data[7:0];
            REG_TRAILER_SECOND: cfg_in.trailer_second = csr_write_data[7:0];
            REG_MAX_LENGTH:     cfg_in.max_length     = csr_write_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first   <= RST_HEADER_FIRST;
         cfg_ff.header_second  <= RST_HEADER_SECOND;
         cfg_ff.trailer_first  <= RST_TRAILER_FIRST;
         cfg_ff.trailer_second <= RST_TRAILER_SECOND;
         cfg_ff.max_length     <= RST_MAX_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register; moves on whenever the queue has a free slot.
   assign advance   = in_valid_ff && (q_count_ff != 2'd2);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   htfr_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .res     (res)
   );

   // Result queue
   assign pop   = rsp_valid && rsp_ready;
   assign q_out = q_ff[q_head_ff];

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff[q_tail_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_head_ff  <= 1'b0;
         q_tail_ff  <= 1'b0;
         q_count_ff <= 2'd0;
      end else begin
         if (advance) q_tail_ff <= ~q_tail_ff;
         if (pop)     q_head_ff <= ~q_head_ff;
         if (advance && !pop) begin
            q_count_ff <= q_count_ff + 2'd1;
         end else if (pop && !advance) begin
            q_count_ff <= q_count_ff - 2'd1;
         end
      end
   end

   assign rsp_valid        = (q_count_ff != 2'd0);
   assign rsp_write_valid  = q_out.write_valid;
   assign rsp_write_addr   = q_out.write_addr;
   assign rsp_write_data   = q_out.write_data;
   assign rsp_frame_done   = q_out.frame_done;
   assign rsp_end_cause    = q_out.end_cause;
   assign rsp_frame_length = q_out.frame_length;

endmodule

/* design/htfr_engine.sv */
// Match-phase state machine and byte counter of the frame receiver.
`timescale 1ns / 1ps

module htfr_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   input  htfr_pkg::cfg_type    cfg,
   output htfr_pkg::result_type res
);
   import htfr_pkg::*;

   // Phases: 0..5 header hunt, 6 waits for trailer_first, 7..11 trailer pairs.
   localparam logic [3:0] PH_HUNT       = 4'd0;
   localparam logic [3:0] PH_BODY       = 4'd6;
   localparam logic [3:0] PH_TRAIL_LAST = 4'd11;
   localparam logic [3:0] PH_UNUSED     = 4'd12;

   logic [3:0]        phase_ff, phase_in, ph;
   logic [ADDR_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0]  n;
   logic [7:0]        want;
   logic              limit;

   always_comb begin
      ph        = (phase_ff >= PH_UNUSED) ? PH_HUNT : phase_ff;
      phase_in  = ph;
      count_in  = count_ff;
      res       = '0;
      n         = LEN_W'({1'b0, count_ff}) + LEN_W'(1);
      limit     = (n >= cfg.max_length) || (17'(n) >= 17'(BUF_DEPTH));
      if (ph < PH_BODY) begin
         want = ph[0] ? cfg.header_second : cfg.header_first;
         if (rx_byte == want) begin
            phase_in = ph + 4'd1;
         end else begin
            phase_in = PH_HUNT;
         end
      end else begin
         want             = ph[0] ? cfg.trailer_second : cfg.trailer_first;
         res.write_valid  = 1'b1;
         res.write_addr   = count_ff;
         res.write_data   = rx_byte;
         res.frame_length = n;
         if (limit) begin
            res.frame_done = 1'b1;
            res.end_cause  = 1'b1;
            count_in       = '0;
            phase_in       = PH_HUNT;
         end else begin
            count_in = n[ADDR_W-1:0];
            if (ph == PH_BODY) begin
               if (rx_byte == cfg.trailer_first) phase_in = PH_BODY + 4'd1;
            end else if (rx_byte != want) begin
               // mismatch: back to waiting, byte not re-checked
               phase_in = PH_BODY;
            end else if (ph == PH_TRAIL_LAST) begin
               res.frame_done = 1'b1;
               count_in       = '0;
               phase_in       = PH_HUNT;
            end else begin
               phase_in = ph + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

/* design/htfr_checker.sv */
// Port-level assertion checker for the frame receiver, with its bind.
`timescale 1ns / 1ps
`include "header_trailer_frame_receiver_macros.svh"

module htfr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_write_valid,
   input logic [htfr_pkg::ADDR_W-1:0] rsp_write_addr,
   input logic [7:0]                  rsp_write_data,
   input logic                        rsp_frame_done,
   input logic                        rsp_end_cause,
   input logic [htfr_pkg::LEN_W-1:0]  rsp_frame_length
);
   import htfr_pkg::*;

   // stalled result word holds
   `HTFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_write_addr) && $stable(rsp_write_data) && $stable(rsp_frame_length) && $stable(rsp_frame_done), "rsp word changed while stalled")

   // header bytes carry an all-zero result
   `HTFR_ASSERT_NOW(a_idle_zero, clock, reset, rsp_valid && !rsp_write_valid, !rsp_frame_done && !rsp_end_cause && rsp_frame_length == '0 && rsp_write_addr == '0 && rsp_write_data == '0, "non-stored word has nonzero fields")

   // for stored words, length is always the address plus one
   `HTFR_ASSERT_NOW(a_len_addr, clock, reset, rsp_valid && rsp_write_valid, rsp_frame_length == LEN_W'({1'b0, rsp_write_addr}) + LEN_W'(1), "frame_length does not track write_addr")

   // a trailer end needs at least three trailer pairs in the frame
   `HTFR_ASSERT_NOW(a_trailer_len, clock, reset, rsp_valid && rsp_frame_done && !rsp_end_cause, rsp_write_valid && rsp_frame_length >= LEN_W'(6), "trailer end on a short frame")

endmodule

bind header_trailer_frame_receiver htfr_checker u_htfr_checker (.*);
